### design/dmsp_pkg.sv
// Package for the dense-matrix shortest path block.
// Holds sizes, operation and status codes, and controller/datapath types.
// No dependencies.
package dmsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W = 6;
    localparam int CNT_W = 7;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DIST_W = 32;
    localparam int WORD_W = DIST_W + 1;
    localparam logic [DIST_W-1:0] DIST_INF = '1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        RES_RANGE,
        RES_SAME,
        RES_MEM
    } res_kind_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_LOAD_WR,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_SCAN_DEC,
        S_RELAX,
        S_RELAX_END,
        S_FINAL_RD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic      latch;
        logic      sweep_start;
        logic      sweep_step;
        logic      load_rd;
        logic      load_wr;
        logic      rd_pair;
        logic      scan_start;
        logic      scan_step;
        logic      mark;
        logic      relax_start;
        logic      relax_step;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       sweep_last;
        logic       range_err;
        logic       same_node;
        logic       pair_done;
        logic       k_last;
        logic       have;
        logic       pick_is_dst;
        logic       out_free;
    } stat_t;

endpackage

### design/dmsp_ctrl.sv
// Controller state machine of the shortest path block.
// Sequences sweeps, loads and the Dijkstra passes; uses dmsp_pkg.
module dmsp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dmsp_pkg::stat_t stat,
    output dmsp_pkg::cmd_t  cmd
);
    import dmsp_pkg::*;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            kind_reg <= RES_MEM;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        cmd = '0;
        cmd.res_kind = kind_reg;
        in_ready = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_LOAD:
                    begin
                        if (stat.range_err)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.load_rd = 1'b1;
                            state_next = S_LOAD_WR;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next = S_SWEEP;
                    end
                    OP_QUERY:
                    begin
                        if (stat.range_err)
                        begin
                            kind_next = RES_RANGE;
                            state_next = S_RESULT;
                        end
                        else if (stat.same_node)
                        begin
                            kind_next = RES_SAME;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_pair = 1'b1;
                            kind_next = RES_MEM;
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOAD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_CHECK:
            begin
                if (stat.pair_done)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.k_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_SCAN_DEC;
            end
            S_SCAN_DEC:
            begin
                if (!stat.have)
                begin
                    state_next = S_FINAL_RD;
                end
                else
                begin
                    cmd.mark = 1'b1;
                    if (stat.pick_is_dst)
                    begin
                        state_next = S_FINAL_RD;
                    end
                    else
                    begin
                        cmd.relax_start = 1'b1;
                        state_next = S_RELAX;
                    end
                end
            end
            S_RELAX:
            begin
                cmd.relax_step = 1'b1;
                if (stat.k_last)
                begin
                    state_next = S_RELAX_END;
                end
            end
            S_RELAX_END:
            begin
                // The last relaxed entry is written back in this cycle.
                cmd.scan_start = 1'b1;
                state_next = S_SCAN;
            end
            S_FINAL_RD:
            begin
                cmd.rd_pair = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/dmsp_dp.sv
// Datapath of the shortest path block: distance memory, scan and relax units.
// Driven by dmsp_ctrl through cmd_t; uses dmsp_pkg.
module dmsp_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dmsp_pkg::CNT_W-1:0]   node_count,
    input  logic [1:0]                   operation,
    input  logic [dmsp_pkg::NODE_W-1:0]  src_node,
    input  logic [dmsp_pkg::NODE_W-1:0]  dst_node,
    input  logic [dmsp_pkg::DIST_W-1:0]  edge_weight,
    input  dmsp_pkg::cmd_t               cmd,
    output dmsp_pkg::stat_t              stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [dmsp_pkg::DIST_W-1:0]  distance
);
    import dmsp_pkg::*;

    logic [WORD_W-1:0] mem [MAX_NODES*MAX_NODES];
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg;

    logic [1:0]        op_reg;
    logic [NODE_W-1:0] src_reg, dst_reg;
    logic [DIST_W-1:0] w_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [NODE_W-1:0] k_reg, k_d_reg;
    logic              scan_v_reg, relax_v_reg;
    logic [DIST_W-1:0] best_reg;
    logic [NODE_W-1:0] pick_reg;
    logic              have_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [DIST_W-1:0] distance_reg;

    logic [CNT_W-1:0]  n_eff;
    logic              rd_a_en, rd_b_en, wr_en;
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [DIST_W:0]   cand_sum;
    logic [DIST_W-1:0] cand;
    logic              relax_wr, scan_take;
    logic [DIST_W-1:0] mem_dist;

    assign n_eff = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

    assign cand_sum = {1'b0, best_reg} + {1'b0, rd_b_reg[DIST_W-1:0]};
    assign cand = cand_sum[DIST_W] ? DIST_INF : cand_sum[DIST_W-1:0];
    assign relax_wr = relax_v_reg && (k_d_reg != src_reg) && (k_d_reg != pick_reg)
                      && !rd_a_reg[DIST_W] && (cand < rd_a_reg[DIST_W-1:0]);
    assign scan_take = scan_v_reg && (k_d_reg != src_reg) && !rd_a_reg[DIST_W]
                       && (rd_a_reg[DIST_W-1:0] < best_reg);

    always_comb
    begin
        rd_a_en = cmd.load_rd | cmd.rd_pair | cmd.scan_step | cmd.relax_step;
        rd_a_addr = (cmd.load_rd | cmd.rd_pair) ? {src_reg, dst_reg} : {src_reg, k_reg};
        rd_b_en = cmd.relax_step;
        rd_b_addr = {pick_reg, k_reg};
        wr_en = 1'b0;
        wr_addr = {src_reg, dst_reg};
        wr_data = {1'b0, DIST_INF};
        if (cmd.sweep_step)
        begin
            wr_en = 1'b1;
            wr_addr = sweep_cnt_reg;
        end
        else if (cmd.load_wr)
        begin
            wr_en = 1'b1;
            wr_data = {rd_a_reg[DIST_W],
                       (w_reg < rd_a_reg[DIST_W-1:0]) ? w_reg : rd_a_reg[DIST_W-1:0]};
        end
        else if (cmd.mark)
        begin
            wr_en = 1'b1;
            wr_addr = {src_reg, pick_reg};
            wr_data = {1'b1, best_reg};
        end
        else if (relax_wr)
        begin
            wr_en = 1'b1;
            wr_addr = {src_reg, k_d_reg};
            wr_data = {1'b0, cand};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= operation;
            src_reg <= src_node;
            dst_reg <= dst_node;
            w_reg <= edge_weight;
        end
        if (cmd.scan_step | cmd.relax_step)
        begin
            k_d_reg <= k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            k_reg <= '0;
            scan_v_reg <= 1'b0;
            relax_v_reg <= 1'b0;
            best_reg <= DIST_INF;
            pick_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.scan_start | cmd.relax_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.scan_step | cmd.relax_step)
            begin
                k_reg <= k_reg + 1'b1;
            end
            scan_v_reg <= cmd.scan_step;
            relax_v_reg <= cmd.relax_step;
            if (cmd.scan_start)
            begin
                best_reg <= DIST_INF;
                have_reg <= 1'b0;
            end
            else if (scan_take)
            begin
                best_reg <= rd_a_reg[DIST_W-1:0];
                pick_reg <= k_d_reg;
                have_reg <= 1'b1;
            end
        end
    end

    assign mem_dist = rd_a_reg[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_RANGE:
                begin
                    status_reg <= ST_RANGE;
                    distance_reg <= DIST_INF;
                end
                RES_SAME:
                begin
                    status_reg <= ST_FOUND;
                    distance_reg <= '0;
                end
                default:
                begin
                    status_reg <= (mem_dist == DIST_INF) ? ST_UNREACH : ST_FOUND;
                    distance_reg <= mem_dist;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign distance = distance_reg;

    always_comb
    begin
        stat.op = op_reg;
        stat.sweep_last = (sweep_cnt_reg == '1);
        stat.range_err = ({1'b0, src_reg} >= n_eff) || ({1'b0, dst_reg} >= n_eff);
        stat.same_node = (src_reg == dst_reg);
        stat.pair_done = rd_a_reg[DIST_W];
        stat.k_last = ({1'b0, k_reg} == (n_eff - 1'b1));
        stat.have = have_reg;
        stat.pick_is_dst = (pick_reg == dst_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

`ifndef SYNTH
    a_relax_row: assert property (@(posedge clk) disable iff (!rst_n)
        relax_wr |-> (wr_addr[ADDR_W-1:NODE_W] == src_reg))
        else $error("relaxation wrote outside the source row");
    a_pipe_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(scan_v_reg && relax_v_reg))
        else $error("scan and relax pipelines active together");
    a_have_finite: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> (best_reg != DIST_INF))
        else $error("picked node has infinite distance");
    a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

### design/dense_matrix_shortest_path.sv
// Dense-matrix shortest path block: a 64x64 distance matrix searched by
// Dijkstra. A clear sweeps the matrix one entry per cycle; the same sweep
// runs after reset, during which no item is accepted. A query that is out
// of range, on one node or whose pair is already settled is answered
// without a search; an unsettled one runs passes that scan the first n
// entries of the source row, each followed by relaxing through the picked
// node, until the destination is picked or none is left, with n the active
// node count. The result waits in an output register so the next item can
// be taken meanwhile. Depends on dmsp_pkg, dmsp_ctrl and dmsp_dp.
module dense_matrix_shortest_path (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [5:0]  src_node,
    input  logic [5:0]  dst_node,
    input  logic [31:0] edge_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] distance
);
    import dmsp_pkg::*;

    logic [CNT_W-1:0] node_count_reg;
    cmd_t             cmd;
    stat_t            stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(MAX_NODES);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, node_count_reg};

    dmsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dmsp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_count  (node_count_reg),
        .operation   (operation),
        .src_node    (src_node),
        .dst_node    (dst_node),
        .edge_weight (edge_weight),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .distance    (distance)
    );

endmodule
